[design/cwg_pkg.sv]
// Shared types and constants for the colour wheel gradient block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cwg_pkg;

  // Channel and register widths
  localparam int CHAN_W      = 12;
  localparam int STEP_W      = 11;
  localparam int STEPV_W     = 10;
  localparam int PHASE_IN_W  = 16;
  localparam int DVD_W       = STEPV_W + CHAN_W;
  localparam int DIV_CNT_W   = 4;

  localparam logic [STEP_W-1:0] MAX_STEPS  = 11'd1024;
  localparam logic [STEP_W-1:0] STEP_RESET = 11'd16;
  localparam logic [STEP_W-1:0] STEP_MIN   = 11'd1;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_TURN   = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Query sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  // One palette entry
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_t;

endpackage

`default_nettype wire

[design/cwg_palette_ram.sv]
// Palette store: one write port, two registered read ports.
// Depends on cwg_pkg for the colour entry type.
`default_nettype none

module cwg_palette_ram import cwg_pkg::*; #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              wen,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire color_t            wdata,
  input  wire logic              ren,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output color_t                 rdata_a,
  output color_t                 rdata_b
);

  color_t mem [DEPTH];

  // Write the appended colour
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Read source and target entries into the output registers
  always_ff @(posedge clk) begin
    if (ren) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[design/cwg_div.sv]
// Restoring divider for one colour channel, one quotient bit per cycle.
// Depends on cwg_pkg; the quotient is known to fit CHAN_W bits.
`default_nettype none

module cwg_div import cwg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [STEP_W-1:0] divisor,
  output logic                   busy,
  output logic [CHAN_W-1:0]      quotient
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [STEP_W-1:0]    rem;
  logic [CHAN_W-1:0]    shreg;
  logic [STEP_W:0]      trial;
  logic [STEP_W:0]      trial_sub;
  logic                 fits;

  // Trial subtraction of the divisor from the shifted remainder
  assign trial     = {rem, shreg[CHAN_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits      = (trial >= {1'b0, divisor});
  assign quotient  = shreg;

  // Control: count the quotient bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == DIV_CNT_W'(CHAN_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: the high dividend bits start below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= STEP_W'(dividend[DVD_W-1:CHAN_W]);
      shreg <= dividend[CHAN_W-1:0];
    end else if (busy) begin
      rem   <= fits ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
      shreg <= {shreg[CHAN_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

[design/color_wheel_gradient_top.sv]
// Colour wheel gradient: palette store, index arithmetic and blend sequencer.
// Depends on cwg_pkg, cwg_palette_ram and cwg_div.
//
// Cyclic colour palette with linear blending between neighbouring colours.
// An append word or a turn word gives no result and leaves the block ready for
// the next word. A query word steps the block through its multiply, load, divide
// and done states, paced by the 12-step restoring dividers (one per channel, run
// side by side) that divide the channel difference times the step position by
// the step count; a query on an empty palette goes straight to done. The result
// register lets the block take the next word while a result waits to be
// taken. step_count may only be written while no query is in progress.
// The palette needs no clearing after reset.
`default_nettype none

module color_wheel_gradient_top import cwg_pkg::*; #(
  parameter int PALETTE_DEPTH = 16,
  parameter int PHASE_BITS    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [STEP_W-1:0]     cfg_wdata,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire logic [1:0]            op,
  input  wire logic [CHAN_W-1:0]     color_red,
  input  wire logic [CHAN_W-1:0]     color_green,
  input  wire logic [CHAN_W-1:0]     color_blue,
  input  wire logic [PHASE_IN_W-1:0] phase,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [CHAN_W-1:0]          out_red,
  output logic [CHAN_W-1:0]          out_green,
  output logic [CHAN_W-1:0]          out_blue,
  output logic                       palette_empty
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = AW + 1;
  localparam int P  = PHASE_BITS;

  state_t state, state_next;

  logic [STEP_W-1:0] step_count;
  logic [CW-1:0]     colour_count;
  logic [P-1:0]      wheel_position;
  logic [P-1:0]      sum;
  logic [STEP_W-1:0] steps;
  logic [P+CW-1:0]   prod_src;
  logic [STEPV_W-1:0] step_pos;
  logic              empty_q;
  logic [2:0]        neg;
  logic [CHAN_W-1:0] base [3];

  logic                  item_acc;
  logic                  palette_full;
  logic                  mem_we;
  logic                  rd_en;
  logic                  div_start;
  logic                  out_load;
  logic                  out_take;
  logic [P+PHASE_IN_W-1:0] phase_wide;
  logic [P-1:0]          phase_ext;
  logic [STEP_W-1:0]     steps_eff;
  logic [AW-1:0]         src_addr;
  logic [CW-1:0]         src_inc;
  logic [AW-1:0]         dst_addr;
  logic [P+STEP_W-1:0]   prod_step;
  color_t                wr_color;
  color_t                rd_src;
  color_t                rd_dst;
  logic [CHAN_W-1:0]     src_ch [3];
  logic [CHAN_W-1:0]     dst_ch [3];
  logic [CHAN_W:0]       diff_ch [3];
  logic [CHAN_W:0]       mag_wide [3];
  logic [DVD_W-1:0]      dvd_ch [3];
  logic [CHAN_W-1:0]     quo_ch [3];
  logic [CHAN_W-1:0]     res_ch [3];
  logic [2:0]            div_busy;

  // Handshake
  assign item_stall   = (state != ST_IDLE);
  assign item_acc     = item_valid && (state == ST_IDLE);
  assign out_take     = result_valid && !result_stall;
  assign palette_full = (colour_count >= CW'(PALETTE_DEPTH));

  // Fold the phase word onto the fraction width
  assign phase_wide = {{P{1'b0}}, phase};
  assign phase_ext  = phase_wide[P-1:0];

  // Clamp the configured step count into its working range
  always_comb begin
    if (step_count == '0) begin
      steps_eff = STEP_MIN;
    end else if (step_count > MAX_STEPS) begin
      steps_eff = MAX_STEPS;
    end else begin
      steps_eff = step_count;
    end
  end

  // Source entry, target entry with wrap, and step within the segment
  assign src_addr  = prod_src[P +: AW];
  assign src_inc   = {1'b0, src_addr} + 1'b1;
  assign dst_addr  = (src_inc == colour_count) ? '0 : src_inc[AW-1:0];
  assign prod_step = (P + STEP_W)'(prod_src[P-1:0]) * (P + STEP_W)'(steps);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          case (op)
            OP_APPEND: mem_we = !palette_full;
            OP_QUERY:  state_next = (colour_count == '0) ? ST_DONE : ST_MUL_A;
            default: ;
          endcase
        end
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: begin
        rd_en      = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (!(|div_busy)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_count <= STEP_RESET;
    end else if (cfg_wen) begin
      step_count <= cfg_wdata;
    end
  end

  // Colour count and wheel position
  always_ff @(posedge clk) begin
    if (rst) begin
      colour_count   <= '0;
      wheel_position <= '0;
    end else begin
      if (mem_we) begin
        colour_count <= colour_count + 1'b1;
      end
      if (item_acc && (op == OP_TURN)) begin
        wheel_position <= wheel_position + phase_ext;
      end
    end
  end

  // Index arithmetic: latch the query, then two registered multiplies
  always_ff @(posedge clk) begin
    if (item_acc && (op == OP_QUERY)) begin
      sum     <= wheel_position + phase_ext;
      steps   <= steps_eff;
      empty_q <= (colour_count == '0);
    end
    if (state == ST_MUL_A) begin
      prod_src <= (P + CW)'(sum) * (P + CW)'(colour_count);
    end
    if (state == ST_MUL_B) begin
      step_pos <= prod_step[P +: STEPV_W];
    end
  end

  // Palette store
  assign wr_color = '{red: color_red, green: color_green, blue: color_blue};

  cwg_palette_ram #(
    .DEPTH  (PALETTE_DEPTH),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wen     (mem_we),
    .waddr   (colour_count[AW-1:0]),
    .wdata   (wr_color),
    .ren     (rd_en),
    .raddr_a (src_addr),
    .raddr_b (dst_addr),
    .rdata_a (rd_src),
    .rdata_b (rd_dst)
  );

  assign src_ch[0] = rd_src.red;
  assign src_ch[1] = rd_src.green;
  assign src_ch[2] = rd_src.blue;
  assign dst_ch[0] = rd_dst.red;
  assign dst_ch[1] = rd_dst.green;
  assign dst_ch[2] = rd_dst.blue;

  // Per-channel blend: divide the magnitude, then restore the sign
  for (genvar c = 0; c < 3; c++) begin : g_chan
    assign diff_ch[c]  = {1'b0, dst_ch[c]} - {1'b0, src_ch[c]};
    assign mag_wide[c] = diff_ch[c][CHAN_W] ? (~diff_ch[c] + 1'b1) : diff_ch[c];
    assign dvd_ch[c]   = DVD_W'(step_pos) * DVD_W'(mag_wide[c][CHAN_W-1:0]);
    assign res_ch[c]   = neg[c] ? (base[c] - quo_ch[c]) : (base[c] + quo_ch[c]);

    // Hold the source value and sign while the divider runs
    always_ff @(posedge clk) begin
      if (state == ST_LOAD) begin
        base[c] <= src_ch[c];
        neg[c]  <= diff_ch[c][CHAN_W];
      end
    end

    cwg_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd_ch[c]),
      .divisor  (steps),
      .busy     (div_busy[c]),
      .quotient (quo_ch[c])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_red       <= empty_q ? '0 : res_ch[0];
      out_green     <= empty_q ? '0 : res_ch[1];
      out_blue      <= empty_q ? '0 : res_ch[2];
      palette_empty <= empty_q;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    colour_count <= CW'(PALETTE_DEPTH))
    else $error("colour count beyond palette depth");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !(|div_busy))
    else $error("divider busy while sequencer idle");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the finish state");

  a_empty_black: assert property (@(posedge clk) disable iff (rst)
    (result_valid && palette_empty) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("empty palette result is not black");

endmodule

`default_nettype wire
